FILE: hw/rtl/clebc_pkg.sv
// ----------------------------------------------------------------------------
// clebc_pkg
// Shared types, key codes and ring pointer helpers for the console line
// edit buffer.
// ----------------------------------------------------------------------------
package clebc_pkg;

  // Ring geometry: pointers count modulo twice the depth
  localparam int BUFFER_DEPTH = 128;
  localparam int PTR_SPAN     = 2 * BUFFER_DEPTH;
  localparam int PTR_W        = $clog2(PTR_SPAN);
  localparam int IDX_W        = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int WIDE_W       = 16;

  // Received key codes
  localparam logic [7:0] KEY_NUL    = 8'h00;
  localparam logic [7:0] KEY_CTRL_D = 8'h04;
  localparam logic [7:0] KEY_CTRL_H = 8'h08;
  localparam logic [7:0] KEY_LF     = 8'h0A;
  localparam logic [7:0] KEY_CR     = 8'h0D;
  localparam logic [7:0] KEY_CTRL_P = 8'h10;
  localparam logic [7:0] KEY_CTRL_U = 8'h15;
  localparam logic [7:0] KEY_DEL    = 8'h7F;

  // Item kinds
  localparam logic KIND_RX   = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // Read status codes
  localparam logic [1:0] RD_NONE  = 2'd0;
  localparam logic [1:0] RD_DATA  = 2'd1;
  localparam logic [1:0] RD_EMPTY = 2'd2;
  localparam logic [1:0] RD_EOF   = 2'd3;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] char_in;
    logic       read_first;
  } item_t;

  typedef struct packed {
    logic       echo_valid;
    logic [7:0] echo_char;
    logic [7:0] erase_count;
    logic       dump_request;
    logic       line_ready;
    logic [1:0] read_status;
    logic [7:0] read_data;
    logic       read_end_of_line;
  } result_t;

  typedef struct packed {
    ptr_t rd;
    ptr_t cm;
    ptr_t ed;
  } ptrs_t;

  typedef struct packed {
    logic       en;
    idx_t       idx;
    logic [7:0] data;
  } wr_t;

  // Advance a pointer with wrap
  function automatic ptr_t ptr_inc(ptr_t p);
    return (p == PTR_W'(PTR_SPAN - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  // Step a pointer back with wrap
  function automatic ptr_t ptr_dec(ptr_t p);
    return (p == '0) ? PTR_W'(PTR_SPAN - 1) : p - PTR_W'(1);
  endfunction

  // Distance from b forward to a
  function automatic ptr_t ptr_diff(ptr_t a, ptr_t b);
    return (a >= b) ? a - b : a + PTR_W'(PTR_SPAN) - b;
  endfunction

  // Ring slot of a pointer
  function automatic idx_t ptr_index(ptr_t p);
    ptr_t r;
    r = (p >= PTR_W'(BUFFER_DEPTH)) ? p - PTR_W'(BUFFER_DEPTH) : p;
    return r[IDX_W-1:0];
  endfunction

endpackage

FILE: hw/rtl/console_line_edit_buffer_core.sv
// ----------------------------------------------------------------------------
// console_line_edit_buffer_core
// Canonical console line editor over a ring with read, commit and edit
// pointers.
// ----------------------------------------------------------------------------
// Usage:
//   The item channel carries either a received UART byte (kind 0) or a
//   reader pop (kind 1). Each beat gives exactly one beat on the result
//   channel, in order: echo, erase count, dump request, line commit and
//   read status with the popped byte.
//   A beat accepted on the item channel is registered in the input register,
//   processed by the edit step into the result register and offered as a
//   result from there.
//   Throughput: one beat per cycle, sustained while results are taken.
//   The byte under the read pointer is always held ready in the line
//   store's registered read port, addressed by the next read pointer.
//   Reset clears the three pointers and both stage registers; the line
//   store itself is not cleared and needs no clearing pass, since a pop
//   only reaches committed bytes.
//   When the receiver stalls, the result register holds its beat, the
//   input register fills and item_ready drops until the result is taken.
// ----------------------------------------------------------------------------
module console_line_edit_buffer_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  clebc_pkg::item_t    item,
  output logic                result_valid,
  input  logic                result_ready,
  output clebc_pkg::result_t  result
);
  import clebc_pkg::*;

  logic    in_full;
  item_t   in_item;
  logic    out_full;
  result_t out_item;
  ptrs_t   ptrs;
  ptrs_t   ptrs_next;
  ptrs_t   step_ptrs;
  wr_t     step_wr;
  result_t step_res;
  logic [7:0] head_byte;
  logic    fire;

  // Process the held beat when the result slot is free or draining
  assign fire       = in_full && (!out_full || result_ready);
  assign item_ready = !in_full || fire;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (item_ready) begin
      in_full <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      in_item <= item;
    end
  end

  clebc_edit u_edit (
    .item      (in_item),
    .ptrs      (ptrs),
    .head_byte (head_byte),
    .ptrs_next (step_ptrs),
    .wr        (step_wr),
    .res       (step_res)
  );

  // Pointer update
  always_comb begin
    if (rst) begin
      ptrs_next = '0;
    end else if (fire) begin
      ptrs_next = step_ptrs;
    end else begin
      ptrs_next = ptrs;
    end
  end

  always_ff @(posedge clk) begin
    ptrs <= ptrs_next;
  end

  // Line store; read port tracks the next read pointer
  clebc_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (fire && step_wr.en),
    .waddr (step_wr.idx),
    .wdata (step_wr.data),
    .raddr (ptr_index(ptrs_next.rd)),
    .rdata (head_byte)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (fire) begin
      out_full <= 1'b1;
    end else if (result_ready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_item <= step_res;
    end
  end

  assign result_valid = out_full;
  assign result       = out_item;

  // Ring never holds more than its depth
  a_ring_bound: assert property (@(posedge clk) disable iff (rst)
    ptr_diff(ptrs.ed, ptrs.rd) <= PTR_W'(BUFFER_DEPTH))
    else $error("ring occupancy exceeds depth");

  // Commit point lies between read and edit pointers
  a_commit_order: assert property (@(posedge clk) disable iff (rst)
    ptr_diff(ptrs.cm, ptrs.rd) <= ptr_diff(ptrs.ed, ptrs.rd))
    else $error("commit pointer outside read..edit span");

  // An accepted beat is held in the input register next cycle
  a_accept_held: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready) |=> in_full)
    else $error("accepted beat lost");

endmodule

FILE: hw/rtl/clebc_ram.sv
// ----------------------------------------------------------------------------
// clebc_ram
// Generic single-write, single-read RAM with registered read; a read of the
// slot written in the same cycle returns the new data.
// ----------------------------------------------------------------------------
module clebc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, write-first on a shared address
  always_ff @(posedge clk) begin
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/clebc_edit.sv
// ----------------------------------------------------------------------------
// clebc_edit
// Line editing step: decodes one beat against the current pointers and the
// byte under the read pointer, giving the result, the store write and the
// updated pointers.
// ----------------------------------------------------------------------------
module clebc_edit (
  input  clebc_pkg::item_t   item,
  input  clebc_pkg::ptrs_t   ptrs,
  input  logic [7:0]         head_byte,
  output clebc_pkg::ptrs_t   ptrs_next,
  output clebc_pkg::wr_t     wr,
  output clebc_pkg::result_t res
);
  import clebc_pkg::*;

  ptr_t             pending;
  ptr_t             uncommitted;
  logic [WIDE_W-1:0] kill_wide;
  logic [7:0]       stored;

  // Ring occupancy and uncommitted length
  assign pending     = ptr_diff(ptrs.ed, ptrs.rd);
  assign uncommitted = ptr_diff(ptrs.ed, ptrs.cm);
  assign kill_wide   = WIDE_W'(uncommitted);
  assign stored      = (item.char_in == KEY_CR) ? KEY_LF : item.char_in;

  always_comb begin
    ptrs_next = ptrs;
    wr        = '0;
    res       = '0;
    wr.idx    = ptr_index(ptrs.ed);
    wr.data   = stored;

    if (item.kind == KIND_RX) begin
      unique case (item.char_in) inside
        KEY_CTRL_P: begin
          res.dump_request = 1'b1;
        end
        KEY_CTRL_U: begin
          // Kill line back to the commit point, saturating the count
          res.erase_count = (kill_wide > WIDE_W'(255)) ? 8'hFF : kill_wide[7:0];
          ptrs_next.ed    = ptrs.cm;
        end
        KEY_CTRL_H, KEY_DEL: begin
          if (ptrs.ed != ptrs.cm) begin
            ptrs_next.ed    = ptr_dec(ptrs.ed);
            res.erase_count = 8'd1;
          end
        end
        default: begin
          // Store and echo a non-NUL byte when there is room; drop otherwise
          if ((item.char_in != KEY_NUL) && (pending < PTR_W'(BUFFER_DEPTH))) begin
            wr.en          = 1'b1;
            res.echo_valid = 1'b1;
            res.echo_char  = stored;
            ptrs_next.ed   = ptr_inc(ptrs.ed);
            if ((stored == KEY_LF) || (stored == KEY_CTRL_D) ||
                (pending == PTR_W'(BUFFER_DEPTH - 1))) begin
              ptrs_next.cm   = ptr_inc(ptrs.ed);
              res.line_ready = 1'b1;
            end
          end
        end
      endcase
    end else begin
      // Pop one committed byte; a Ctrl-D is popped only on a first read
      if (ptrs.rd == ptrs.cm) begin
        res.read_status = RD_EMPTY;
      end else if (head_byte == KEY_CTRL_D) begin
        res.read_status = RD_EOF;
        if (item.read_first) begin
          ptrs_next.rd = ptr_inc(ptrs.rd);
        end
      end else begin
        ptrs_next.rd         = ptr_inc(ptrs.rd);
        res.read_status      = RD_DATA;
        res.read_data        = head_byte;
        res.read_end_of_line = (head_byte == KEY_LF);
      end
    end
  end

endmodule
